// File: hdl/distance_field_match_score_assert.svh
// Assertion macros shared by the distance field match score modules.
`ifndef DISTANCE_FIELD_MATCH_SCORE_ASSERT_SVH
`define DISTANCE_FIELD_MATCH_SCORE_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define DFMS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its cause.
`define DFMS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that holds in the cycle after its cause.
`define DFMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dfms_pkg.sv
// Shared types and constants of the distance field match score block.
package dfms_pkg;

    localparam int ADDR_W         = 18;
    localparam int STORE_DEPTH    = 262144;
    localparam int IDX_W          = 8;
    localparam int QUEUE_DEPTH    = 4;
    localparam int DFLT_DIM_I     = 64;
    localparam int DFLT_DIM_J     = 64;
    localparam int DFLT_DIM_K     = 64;
    localparam int DFLT_DIST_BITS = 16;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BEST_SUM = 3'd6;

    typedef struct packed {
        logic signed [31:0] gain_x;
        logic signed [31:0] gain_y;
        logic signed [31:0] gain_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic        [31:0] best_sum;
    } cfg_t;

    typedef struct packed {
        logic              is_point;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       value;
    } op_t;

endpackage

// File: hdl/dfms_if.sv
// Request and result channel interfaces of the distance field match score block.
interface dfms_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [17:0]        field_addr;
    logic [15:0]        field_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;

    modport source (
        output valid, kind, field_addr, field_value, point_x, point_y, point_z, last_point,
        input  ready
    );
    modport sink (
        input  valid, kind, field_addr, field_value, point_x, point_y, point_z, last_point,
        output ready
    );
endinterface

interface dfms_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] total;
    logic        stopped_early;

    modport source (output valid, total, stopped_early, input ready);
    modport sink (input valid, total, stopped_early, output ready);
endinterface

// File: hdl/dfms_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dfms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/dfms_queue.sv
// Short FIFO of classified requests between the front and back parts.
`include "distance_field_match_score_assert.svh"

module dfms_queue import dfms_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  op_t  push_data,
    input  logic push_valid,
    output logic push_ready,
    output op_t  pop_data,
    output logic pop_valid,
    input  logic pop_ready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `DFMS_ASSERT(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

// File: hdl/dfms_front.sv
// Front part: accepts requests, scales points into grid cells and forms field addresses.
module dfms_front import dfms_pkg::*; #(
    parameter int DIM_I = DFLT_DIM_I,
    parameter int DIM_J = DFLT_DIM_J,
    parameter int DIM_K = DFLT_DIM_K
) (
    input  logic       clk,
    input  logic       rst_n,
    dfms_in_if.sink    items,
    input  cfg_t       cfg,
    output op_t        op,
    output logic       op_valid,
    input  logic       op_ready
);

    localparam logic [IDX_W-1:0]  LIM_I = IDX_W'(DIM_I - 1);
    localparam logic [IDX_W-1:0]  LIM_J = IDX_W'(DIM_J - 1);
    localparam logic [IDX_W-1:0]  LIM_K = IDX_W'(DIM_K - 1);
    localparam logic [ADDR_W-1:0] ROW   = ADDR_W'(DIM_I);
    localparam logic [ADDR_W-1:0] PLANE = ADDR_W'(DIM_I * DIM_J);

    // The index is the integer part of the Q32.32 sum, clamped into the grid.
    function automatic logic [IDX_W-1:0] clamp_index(
        input logic signed [63:0] prod,
        input logic signed [31:0] offset,
        input logic [IDX_W-1:0]   lim
    );
        logic signed [63:0] v;
        logic [IDX_W-1:0]   idx;
        v = prod + {{16{offset[31]}}, offset, 16'h0000};
        if (v[63])
        begin
            idx = '0;
        end
        else if (v[63:32] > {{(32-IDX_W){1'b0}}, lim})
        begin
            idx = lim;
        end
        else
        begin
            idx = v[IDX_W+31:32];
        end
        return idx;
    endfunction

    logic               f1_valid_reg, f1_valid_next;
    logic               f1_point_reg, f1_last_reg;
    logic [ADDR_W-1:0]  f1_addr_reg;
    logic [15:0]        f1_value_reg;
    logic signed [63:0] f1_prod_x_reg, f1_prod_y_reg, f1_prod_z_reg;

    logic               f2_valid_reg, f2_valid_next;
    logic               f2_point_reg, f2_last_reg;
    logic [ADDR_W-1:0]  f2_addr_reg;
    logic [15:0]        f2_value_reg;
    logic [IDX_W-1:0]   f2_i_reg, f2_j_reg, f2_k_reg;

    logic               f3_valid_reg, f3_valid_next;
    op_t                op_reg, op_next;

    logic               f1_load, f2_load, f3_load;
    logic               f1_move, f2_move, f3_move;
    logic [ADDR_W-1:0]  cell_addr;

    assign f3_move = f3_valid_reg && op_ready;
    assign f3_load = !f3_valid_reg || f3_move;
    assign f2_move = f2_valid_reg && f3_load;
    assign f2_load = !f2_valid_reg || f2_move;
    assign f1_move = f1_valid_reg && f2_load;
    assign f1_load = !f1_valid_reg || f1_move;

    assign items.ready = f1_load;
    assign op          = op_reg;
    assign op_valid    = f3_valid_reg;

    assign cell_addr = ADDR_W'(f2_k_reg) * PLANE + ADDR_W'(f2_j_reg) * ROW
                     + ADDR_W'(f2_i_reg);

    always_comb
    begin
        f1_valid_next = f1_load ? items.valid : f1_valid_reg;
        f2_valid_next = f2_load ? f1_valid_reg : f2_valid_reg;
        f3_valid_next = f3_load ? f2_valid_reg : f3_valid_reg;
        op_next.is_point = f2_point_reg;
        op_next.last     = f2_last_reg;
        op_next.addr     = f2_point_reg ? cell_addr : f2_addr_reg;
        op_next.value    = f2_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
            f3_valid_reg <= f3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_load)
        begin
            f1_point_reg  <= items.kind;
            f1_last_reg   <= items.last_point;
            f1_addr_reg   <= items.field_addr;
            f1_value_reg  <= items.field_value;
            f1_prod_x_reg <= cfg.gain_x * items.point_x;
            f1_prod_y_reg <= cfg.gain_y * items.point_y;
            f1_prod_z_reg <= cfg.gain_z * items.point_z;
        end
        if (f2_load)
        begin
            f2_point_reg <= f1_point_reg;
            f2_last_reg  <= f1_last_reg;
            f2_addr_reg  <= f1_addr_reg;
            f2_value_reg <= f1_value_reg;
            f2_i_reg     <= clamp_index(f1_prod_x_reg, cfg.offset_x, LIM_I);
            f2_j_reg     <= clamp_index(f1_prod_y_reg, cfg.offset_y, LIM_J);
            f2_k_reg     <= clamp_index(f1_prod_z_reg, cfg.offset_z, LIM_K);
        end
        if (f3_load)
        begin
            op_reg <= op_next;
        end
    end

endmodule

// File: hdl/dfms_back.sv
// Back part: field store access, saturating run sum, early stop and result register.
`include "distance_field_match_score_assert.svh"

module dfms_back import dfms_pkg::*; #(
    parameter int DIST_BITS = DFLT_DIST_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  op_t         head,
    input  logic        head_valid,
    output logic        head_ready,
    input  logic [31:0] best_sum,
    dfms_out_if.source  results
);

    logic                 en, pop, b_fire, emit, over;
    logic                 ram_we, ram_re;
    logic [DIST_BITS-1:0] field_dist;
    logic [32:0]          sum_wide;
    logic [31:0]          sat;

    logic                 b_valid_reg, b_valid_next;
    logic                 b_last_reg, b_last_next;
    logic [31:0]          sum_reg, sum_next;
    logic                 skip_reg, skip_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          total_reg, total_next;
    logic                 early_reg, early_next;

    assign en         = !out_valid_reg || results.ready;
    assign head_ready = en;
    assign pop        = en && head_valid;
    assign ram_we     = pop && !head.is_point;
    assign ram_re     = pop && head.is_point;
    assign b_fire     = en && b_valid_reg;

    dfms_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head.addr),
        .wdata (DIST_BITS'(head.value)),
        .re    (ram_re),
        .raddr (head.addr),
        .rdata (field_dist)
    );

    assign sum_wide = {1'b0, sum_reg} + 33'(field_dist);
    assign sat      = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
    assign over     = sat > best_sum;

    always_comb
    begin
        b_valid_next   = en ? (pop && head.is_point) : b_valid_reg;
        b_last_next    = en ? head.last : b_last_reg;
        sum_next       = sum_reg;
        skip_next      = skip_reg;
        out_valid_next = en ? 1'b0 : out_valid_reg;
        total_next     = total_reg;
        early_next     = early_reg;
        emit           = 1'b0;
        if (b_fire)
        begin
            if (skip_reg)
            begin
                if (b_last_reg)
                begin
                    skip_next = 1'b0;
                    sum_next  = '0;
                end
            end
            else
            begin
                emit = over || b_last_reg;
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    total_next     = sat;
                    early_next     = over;
                end
                if (b_last_reg)
                begin
                    sum_next  = '0;
                    skip_next = 1'b0;
                end
                else
                begin
                    sum_next  = sat;
                    skip_next = over;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            sum_reg       <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            sum_reg       <= sum_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_last_reg <= b_last_next;
        total_reg  <= total_next;
        early_reg  <= early_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.total         = total_reg;
    assign results.stopped_early = early_reg;

    `DFMS_ASSERT(a_one_store_access, !(ram_we && ram_re), "store written and read together")
    `DFMS_ASSERT_NEXT(a_skip_silent, b_fire && skip_reg, !out_valid_reg, "result while skipping")
    `DFMS_ASSERT_NEXT(a_early_skips, b_fire && emit && !b_last_reg, skip_reg, "early stop lost")

endmodule

// File: hdl/distance_field_match_score.sv
// Top level of the distance field match score block.
// Requests arrive on items: kind 0 writes field_value into the distance field at
// field_addr, kind 1 presents a model point of a run, and last_point closes the run.
// Each point is scaled into a clamped grid cell and its stored distance is added to
// a saturating run sum. A result on results carries the sum and stopped_early; it
// appears when the sum first exceeds best_sum or at the last point of the run.
// Points after an early stop give no result until the run ends.
// Throughput is one request per cycle while results is not stalled. A result
// becomes valid once its point has passed the multiplier, clamp and address
// registers, the queue and the field store read.
// The user must write the registers on cfg_we only while no request is in flight;
// the block itself does not enforce it. Reset clears the run sum and the pipeline
// and loads the register defaults; the distance field itself holds no defined
// value until it is written. When results is stalled, the back part holds, the
// queue fills and items drops ready once the front stages are full.
module distance_field_match_score import dfms_pkg::*; #(
    parameter int DIM_I     = DFLT_DIM_I,
    parameter int DIM_J     = DFLT_DIM_J,
    parameter int DIM_K     = DFLT_DIM_K,
    parameter int DIST_BITS = DFLT_DIST_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    dfms_in_if.sink              items,
    dfms_out_if.source           results,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t cfg_reg, cfg_next;
    op_t  front_op, head_op;
    logic front_valid, front_ready, head_valid, head_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_X:   cfg_next.gain_x   = cfg_data;
                REG_GAIN_Y:   cfg_next.gain_y   = cfg_data;
                REG_GAIN_Z:   cfg_next.gain_z   = cfg_data;
                REG_OFFSET_X: cfg_next.offset_x = cfg_data;
                REG_OFFSET_Y: cfg_next.offset_y = cfg_data;
                REG_OFFSET_Z: cfg_next.offset_z = cfg_data;
                REG_BEST_SUM: cfg_next.best_sum = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_x   <= 32'sh0001_0000;
            cfg_reg.gain_y   <= 32'sh0001_0000;
            cfg_reg.gain_z   <= 32'sh0001_0000;
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
            cfg_reg.offset_z <= '0;
            cfg_reg.best_sum <= 32'hFFFF_FFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dfms_front #(
        .DIM_I (DIM_I),
        .DIM_J (DIM_J),
        .DIM_K (DIM_K)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .cfg      (cfg_reg),
        .op       (front_op),
        .op_valid (front_valid),
        .op_ready (front_ready)
    );

    dfms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_op),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (head_op),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready)
    );

    dfms_back #(
        .DIST_BITS (DIST_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_op),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .best_sum   (cfg_reg.best_sum),
        .results    (results)
    );

endmodule

// File: tb/tb_distance_field_match_score.sv
// Self-checking testbench of the distance field match score block with a scoreboard class.
`timescale 1ns / 1ps

module tb_distance_field_match_score import dfms_pkg::*; ();

    localparam int DIM_I = DFLT_DIM_I;
    localparam int DIM_J = DFLT_DIM_J;
    localparam int DIM_K = DFLT_DIM_K;
    localparam int DIST_BITS = DFLT_DIST_BITS;
    localparam logic [15:0] DIST_MASK = 16'((64'd1 << DIST_BITS) - 1);

    localparam bit KIND_WRITE = 1'b0;
    localparam bit KIND_POINT = 1'b1;

    localparam int RANDOM_REQUESTS = 800;
    localparam int PHASE_REQUESTS = 100;
    localparam int SETTLE_CYCLES = 12;
    localparam int TIMEOUT_NS = 6_000_000;

    class score_tracker;
        typedef struct {
            logic [31:0] total;
            logic        stopped_early;
        } score_t;

        cfg_t        cfg;
        bit [15:0]   dist_store [STORE_DEPTH];
        bit          written [STORE_DEPTH];
        logic [31:0] run_sum;
        bit          skipping;
        score_t      expected_scores [$];
        int          requests;
        int          scores;
        int          early_stops;
        int          errors;

        function new();
            cfg.gain_x   = 32'sd65536;
            cfg.gain_y   = 32'sd65536;
            cfg.gain_z   = 32'sd65536;
            cfg.offset_x = '0;
            cfg.offset_y = '0;
            cfg.offset_z = '0;
            cfg.best_sum = '1;
            run_sum = '0;
            skipping = 1'b0;
            requests = 0;
            scores = 0;
            early_stops = 0;
            errors = 0;
        endfunction

        function int unsigned axis_index(logic signed [31:0] g, logic signed [31:0] o,
                                         logic signed [31:0] c, int dim);
            longint v;
            longint idx;
            v = longint'(g) * longint'(c) + longint'(o) * 64'sd65536;
            if (v < 0)
                return 0;
            idx = v >>> 32;
            if (idx > dim - 1)
                idx = dim - 1;
            return idx[31:0];
        endfunction

        function logic [ADDR_W-1:0] cell_of(logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [31:0] z);
            longint a;
            a = longint'(axis_index(cfg.gain_z, cfg.offset_z, z, DIM_K)) * DIM_I * DIM_J
              + longint'(axis_index(cfg.gain_y, cfg.offset_y, y, DIM_J)) * DIM_I
              + longint'(axis_index(cfg.gain_x, cfg.offset_x, x, DIM_I));
            return a[ADDR_W-1:0];
        endfunction

        function void note_request(bit kind, logic [ADDR_W-1:0] addr, logic [15:0] value,
                                   logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z, bit is_last);
            logic [32:0]       s;
            bit                over;
            score_t            sc;
            logic [ADDR_W-1:0] grid_addr;
            requests++;
            if (kind == KIND_WRITE)
            begin
                dist_store[addr] = value & DIST_MASK;
                written[addr] = 1'b1;
                return;
            end
            if (skipping)
            begin
                if (is_last)
                begin
                    skipping = 1'b0;
                    run_sum = '0;
                end
                return;
            end
            grid_addr = cell_of(x, y, z);
            s = {1'b0, run_sum} + dist_store[grid_addr];
            run_sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
            over = run_sum > cfg.best_sum;
            if (!over && !is_last)
                return;
            sc.total = run_sum;
            sc.stopped_early = over;
            expected_scores.push_back(sc);
            if (is_last)
            begin
                run_sum = '0;
                skipping = 1'b0;
            end
            else
                skipping = 1'b1;
        endfunction

        function void check_score(logic [31:0] total, logic stopped_early);
            score_t e;
            if (expected_scores.size() == 0)
            begin
                $error("unexpected score: total %0d, stopped_early %0b", total, stopped_early);
                errors++;
                return;
            end
            e = expected_scores.pop_front();
            if (total !== e.total)
            begin
                $error("total: expected %0d, got %0d", e.total, total);
                errors++;
            end
            if (stopped_early !== e.stopped_early)
            begin
                $error("stopped_early: expected %0b, got %0b", e.stopped_early, stopped_early);
                errors++;
            end
            scores++;
            if (e.stopped_early)
                early_stops++;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    bit                   idle_on;
    int                   configs;

    dfms_in_if  items_if ();
    dfms_out_if results_if ();

    score_tracker sb = new();

    distance_field_match_score #(
        .DIM_I     (DIM_I),
        .DIM_J     (DIM_J),
        .DIM_K     (DIM_K),
        .DIST_BITS (DIST_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        results_if.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                results_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            sb.check_score(results_if.total, results_if.stopped_early);
    end

    task automatic send_request(bit kind, logic [ADDR_W-1:0] addr, logic [15:0] value,
                                logic signed [31:0] x, logic signed [31:0] y,
                                logic signed [31:0] z, bit is_last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            items_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        items_if.kind        <= kind;
        items_if.field_addr  <= addr;
        items_if.field_value <= value;
        items_if.point_x     <= x;
        items_if.point_y     <= y;
        items_if.point_z     <= z;
        items_if.last_point  <= is_last;
        items_if.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!items_if.ready);
        sb.note_request(kind, addr, value, x, y, z, is_last);
    endtask

    task automatic write_field(logic [ADDR_W-1:0] addr, logic [15:0] value);
        send_request(KIND_WRITE, addr, value, $urandom, $urandom, $urandom,
                     $urandom_range(0, 1));
    endtask

    function automatic logic [15:0] random_distance();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // A point may only read a cell that holds a value, so an empty cell is filled first.
    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, bit is_last);
        logic [ADDR_W-1:0] grid_addr;
        grid_addr = sb.cell_of(x, y, z);
        if (!sb.written[grid_addr])
            write_field(grid_addr, random_distance());
        send_request(KIND_POINT, ADDR_W'($urandom), 16'($urandom), x, y, z, is_last);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(cfg_t c);
        write_reg(REG_GAIN_X, c.gain_x);
        write_reg(REG_GAIN_Y, c.gain_y);
        write_reg(REG_GAIN_Z, c.gain_z);
        write_reg(REG_OFFSET_X, c.offset_x);
        write_reg(REG_OFFSET_Y, c.offset_y);
        write_reg(REG_OFFSET_Z, c.offset_z);
        write_reg(REG_BEST_SUM, c.best_sum);
        cfg_we <= 1'b0;
        sb.cfg = c;
        configs++;
    endtask

    task automatic settle();
        items_if.valid <= 1'b0;
        while (sb.expected_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [31:0] grid_coord(int n);
        return n <<< 16;
    endfunction

    function automatic cfg_t unit_config(logic [31:0] best);
        cfg_t c;
        c.gain_x   = 32'sd65536;
        c.gain_y   = 32'sd65536;
        c.gain_z   = 32'sd65536;
        c.offset_x = '0;
        c.offset_y = '0;
        c.offset_z = '0;
        c.best_sum = best;
        return c;
    endfunction

    function automatic logic signed [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 32'sd65536;
            1: return 32'sd262144;
            2: return -32'sd65536;
            3: return 32'sh7FFF_FFFF;
            4: return 32'sh8000_0000;
            5: return 32'sd0;
            6: return $urandom;
            default: return $urandom_range(16384, 1048576);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return 32'sd0;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            3: return grid_coord(63);
            4: return $urandom;
            default: return $urandom_range(0, 72 << 16) - (8 << 16);
        endcase
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.gain_x   = pick_gain();
        c.gain_y   = pick_gain();
        c.gain_z   = pick_gain();
        c.offset_x = pick_offset();
        c.offset_y = pick_offset();
        c.offset_z = pick_offset();
        case ($urandom_range(0, 5))
            0: c.best_sum = '0;
            1: c.best_sum = '1;
            2: c.best_sum = $urandom;
            default: c.best_sum = $urandom_range(0, 400000);
        endcase
        return c;
    endfunction

    // Aims at a cell near the grid by inverting the scaling, with some edge coordinates mixed in.
    function automatic logic signed [31:0] coord_for(logic signed [31:0] g,
                                                     logic signed [31:0] o, int dim);
        longint num;
        longint q;
        int     t;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default:
            begin
                if (g == 0)
                    return $urandom;
                t = $urandom_range(0, dim + 3) - 2;
                num = (longint'(t) <<< 32) + longint'($urandom) - longint'(o) * 64'sd65536;
                q = num / longint'(g);
                if (q > 64'sh7FFF_FFFF)
                    q = 64'sh7FFF_FFFF;
                if (q < -64'sh8000_0000)
                    q = -64'sh8000_0000;
                return q[31:0];
            end
        endcase
    endfunction

    initial
    begin
        int phase_end;
        int run_len;
        int random_end;
        items_if.valid       = 1'b0;
        items_if.kind        = KIND_WRITE;
        items_if.field_addr  = '0;
        items_if.field_value = '0;
        items_if.point_x     = '0;
        items_if.point_y     = '0;
        items_if.point_z     = '0;
        items_if.last_point  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_GAIN_X;
        cfg_data  = '0;
        idle_on   = 1'b1;
        configs   = 0;
        rst_n     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults after reset: unit gains, no offset, no early stop.
        send_request(KIND_WRITE, '0, 16'h0000, '0, '0, '0, 1'b1);
        send_request(KIND_WRITE, '1, 16'hFFFF, '1, '1, '1, 1'b0);
        write_field(ADDR_W'(4096 + 2 * 64 + 3), 16'h1234);
        write_field(5, 16'h0007);
        write_field(10, 16'd60);
        send_point(grid_coord(0), grid_coord(0), grid_coord(0), 1'b0);
        send_point(grid_coord(3) + 32'sh8000, grid_coord(2) + 32'sh4000, grid_coord(1), 1'b0);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        write_field(7, 16'h00FF);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        send_point(grid_coord(5), -32'sd1, grid_coord(70), 1'b1);
        settle();

        // Early stop mid-run, skipped points and writes, and a stop on the last point.
        apply_config(unit_config(32'd100));
        send_point(grid_coord(10), '0, '0, 1'b0);
        send_point(grid_coord(10), '0, '0, 1'b0);
        send_point(grid_coord(5), '0, '0, 1'b0);
        write_field(11, 16'd5);
        send_point(grid_coord(10), '0, '0, 1'b1);
        send_point(grid_coord(10), '0, '0, 1'b1);
        send_point(grid_coord(10), '0, '0, 1'b0);
        send_point(grid_coord(10), '0, '0, 1'b1);
        settle();

        // A sum equal to the best sum does not stop the run.
        apply_config(unit_config(32'd120));
        send_point(grid_coord(10), '0, '0, 1'b0);
        send_point(grid_coord(10), '0, '0, 1'b1);
        settle();

        apply_config(unit_config(32'd0));
        send_point('0, '0, '0, 1'b1);
        send_point(grid_coord(5), '0, '0, 1'b0);
        send_point('0, '0, '0, 1'b1);
        settle();

        random_end = sb.requests + RANDOM_REQUESTS;
        while (sb.requests < random_end)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (random_end - sb.requests <= PHASE_REQUESTS)
                idle_on = 1'b0;
            apply_config(random_config());
            phase_end = sb.requests + PHASE_REQUESTS;
            while (sb.requests < phase_end)
            begin
                if ($urandom_range(0, 6) == 0)
                    write_field(ADDR_W'($urandom), random_distance());
                else
                begin
                    run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                          : $urandom_range(1, 10);
                    for (int p = 1; p <= run_len; p++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            write_field(ADDR_W'($urandom), random_distance());
                        send_point(coord_for(sb.cfg.gain_x, sb.cfg.offset_x, DIM_I),
                                   coord_for(sb.cfg.gain_y, sb.cfg.offset_y, DIM_J),
                                   coord_for(sb.cfg.gain_z, sb.cfg.offset_z, DIM_K),
                                   p == run_len);
                    end
                end
            end
            settle();
        end

        $display("Checked %0d scores (%0d stopped early) from %0d requests under %0d settings,",
                 sb.scores, sb.early_stops, sb.requests, configs);
        $display("with clamped grid indices, skipped points and stalls on both channels.");
        if (sb.errors == 0 && sb.expected_scores.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
